>>> src/ecetbl_pkg.sv
// Shared types, operation codes and control bundles for the event counter table.
package ecetbl_pkg;

  // Fixed payload widths
  typedef logic [1:0]  op_t;
  typedef logic [7:0]  idx8_t;
  typedef logic [31:0] word_t;

  // Operation codes
  localparam op_t OP_RECORD = 2'd0;
  localparam op_t OP_READ   = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;        // capture the request beat
    logic sweep_slice;  // load the sweep range with the current CPU's slice
    logic sweep_step;   // write zero at the sweep address and advance
    logic sync_epoch;   // tag the current CPU with the global epoch
    logic clear_epoch;  // advance the global epoch and tag the current CPU
    logic inc_rd;       // read the addressed counter
    logic inc_wr;       // write back the counter plus one
    logic rd_init;      // start the summing loop at CPU 0
    logic rd_issue;     // read the counter of the loop CPU
    logic rd_acc;       // accumulate and move to the next CPU
    logic rsp_load;     // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;           // latched operation
    logic idx_ok;       // subsystem and counter index in range
    logic cpu_stale;    // current CPU's epoch differs from the global epoch
    logic sweep_last;   // sweep address is at the end of its range
    logic cpu_last;     // summing loop is at the last CPU
    logic out_free;     // result register can take a new beat
  } sts_t;

endpackage

>>> src/ecetbl_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface ecetbl_req_if;
  logic                  valid;
  logic                  ready;
  ecetbl_pkg::op_t       operation;
  ecetbl_pkg::idx8_t     cpu_id;
  ecetbl_pkg::idx8_t     subsystem;
  ecetbl_pkg::idx8_t     counter_index;

  modport source (output valid, operation, cpu_id, subsystem, counter_index,
                  input ready);
  modport sink   (input valid, operation, cpu_id, subsystem, counter_index,
                  output ready);
endinterface

>>> src/ecetbl_rsp_if.sv
// Result channel: valid/ready handshake with status and count.
interface ecetbl_rsp_if;
  logic                  valid;
  logic                  ready;
  logic                  status;
  ecetbl_pkg::word_t     count;

  modport source (output valid, status, count, input ready);
  modport sink   (input valid, status, count, output ready);
endinterface

>>> src/ecetbl_ctrl.sv
// Controller state machine sequencing sweeps, read-modify-writes and sums.
module ecetbl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ecetbl_pkg::sts_t   sts,
  output ecetbl_pkg::cmd_t   cmd
);

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_EXEC     = 4'd2;
  localparam logic [3:0] ST_SWEEP    = 4'd3;
  localparam logic [3:0] ST_INC_RD   = 4'd4;
  localparam logic [3:0] ST_INC_WR   = 4'd5;
  localparam logic [3:0] ST_RD_ISSUE = 4'd6;
  localparam logic [3:0] ST_RD_ACC   = 4'd7;
  localparam logic [3:0] ST_RESP     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register; reset starts the full table sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.op)
          ecetbl_pkg::OP_RECORD: begin
            if (!sts.idx_ok) begin
              state_next = ST_RESP;
            end else if (sts.cpu_stale) begin
              cmd.sweep_slice = 1'b1;
              state_next      = ST_SWEEP;
            end else begin
              state_next = ST_INC_RD;
            end
          end
          ecetbl_pkg::OP_READ: begin
            if (sts.idx_ok) begin
              cmd.rd_init = 1'b1;
              state_next  = ST_RD_ISSUE;
            end else begin
              state_next = ST_RESP;
            end
          end
          ecetbl_pkg::OP_CLEAR: begin
            cmd.clear_epoch = 1'b1;
            cmd.sweep_slice = 1'b1;
            state_next      = ST_SWEEP;
          end
          default: begin
            state_next = ST_RESP;
          end
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          if (sts.op == ecetbl_pkg::OP_RECORD) begin
            cmd.sync_epoch = 1'b1;
            state_next     = ST_INC_RD;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_INC_RD: begin
        cmd.inc_rd = 1'b1;
        state_next = ST_INC_WR;
      end
      ST_INC_WR: begin
        cmd.inc_wr = 1'b1;
        state_next = ST_RESP;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_ACC;
      end
      ST_RD_ACC: begin
        cmd.rd_acc = 1'b1;
        state_next = sts.cpu_last ? ST_RESP : ST_RD_ISSUE;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/ecetbl_dp.sv
// Datapath: counter memory, epoch tags, sweep and summing counters, result register.
module ecetbl_dp #(
  parameter int NUM_CPUS       = 4,
  parameter int NUM_SUBSYSTEMS = 8,
  parameter int NUM_COUNTERS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ecetbl_pkg::cmd_t   cmd,
  output ecetbl_pkg::sts_t   sts,
  input  ecetbl_pkg::op_t    in_operation,
  input  ecetbl_pkg::idx8_t  in_cpu_id,
  input  ecetbl_pkg::idx8_t  in_subsystem,
  input  ecetbl_pkg::idx8_t  in_counter_index,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_status,
  output ecetbl_pkg::word_t  out_count
);

  localparam int SLICE = NUM_SUBSYSTEMS * NUM_COUNTERS;
  localparam int TABLE = NUM_CPUS * SLICE;
  localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;
  localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // Latched request
  ecetbl_pkg::op_t   op_q;
  logic [CW-1:0]     cpu_q;
  logic              ok_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     base_q;

  // Request decode
  logic              cpu_in_range;
  logic [CW-1:0]     cpu_map;
  logic              ok_in;
  logic [AW-1:0]     base_in;

  assign cpu_in_range = in_cpu_id < 8'(NUM_CPUS);
  assign cpu_map      = cpu_in_range ? CW'(in_cpu_id) : '0;
  assign ok_in        = (in_subsystem < 8'(NUM_SUBSYSTEMS)) &&
                        (in_counter_index < 8'(NUM_COUNTERS));
  assign base_in      = AW'(in_subsystem) * AW'(NUM_COUNTERS) + AW'(in_counter_index);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= in_operation;
      cpu_q  <= cpu_map;
      ok_q   <= ok_in;
      base_q <= base_in;
      idx_q  <= AW'(cpu_map) * AW'(SLICE) + base_in;
    end
  end

  // Epoch tags; each compare sits at a fixed place.
  ecetbl_pkg::word_t global_epoch;
  ecetbl_pkg::word_t cpu_epoch [NUM_CPUS];
  logic [NUM_CPUS-1:0] cur_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_epoch <= 32'd1;
      for (int c = 0; c < NUM_CPUS; c++) begin
        cpu_epoch[c] <= 32'd1;
      end
    end else if (cmd.clear_epoch) begin
      global_epoch     <= global_epoch + 32'd1;
      cpu_epoch[cpu_q] <= global_epoch + 32'd1;
    end else if (cmd.sync_epoch) begin
      cpu_epoch[cpu_q] <= global_epoch;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CPUS; c++) begin
      cur_vec[c] = (cpu_epoch[c] == global_epoch);
    end
  end

  // Sweep range for the reset pass and slice zeroing.
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] sweep_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_end  <= AW'(TABLE - 1);
    end else if (cmd.sweep_slice) begin
      sweep_addr <= AW'(cpu_q) * AW'(SLICE);
      sweep_end  <= AW'(cpu_q) * AW'(SLICE) + AW'(SLICE - 1);
    end else if (cmd.sweep_step) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  // Summing loop over CPUs.
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     loop_cpu;
  ecetbl_pkg::word_t acc;
  ecetbl_pkg::word_t rdata;

  always_ff @(posedge clk) begin
    if (cmd.rd_init) begin
      rd_addr  <= base_q;
      loop_cpu <= '0;
      acc      <= '0;
    end else if (cmd.rd_acc) begin
      if (cur_vec[loop_cpu]) begin
        acc <= acc + rdata;
      end
      rd_addr  <= rd_addr + AW'(SLICE);
      loop_cpu <= loop_cpu + CW'(1);
    end
  end

  // Counter memory: one write port, one registered read port.
  ecetbl_pkg::word_t mem [TABLE];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  ecetbl_pkg::word_t mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  assign mem_we    = cmd.sweep_step | cmd.inc_wr;
  assign mem_waddr = cmd.inc_wr ? idx_q : sweep_addr;
  assign mem_wdata = cmd.inc_wr ? rdata + 32'd1 : '0;
  assign mem_re    = cmd.inc_rd | cmd.rd_issue;
  assign mem_raddr = cmd.inc_rd ? idx_q : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      out_status <= (op_q == ecetbl_pkg::OP_RECORD && !ok_q) ?
                    ecetbl_pkg::STATUS_ERR : ecetbl_pkg::STATUS_OK;
      out_count  <= (op_q == ecetbl_pkg::OP_READ && ok_q) ? acc : '0;
    end
  end

  // Status to the controller
  assign sts.op         = op_q;
  assign sts.idx_ok     = ok_q;
  assign sts.cpu_stale  = !cur_vec[cpu_q];
  assign sts.sweep_last = (sweep_addr == sweep_end);
  assign sts.cpu_last   = (loop_cpu == CW'(NUM_CPUS - 1));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

>>> src/epoch_cleared_event_counter_table_unit.sv
// A bad record or read, or an unused code, goes straight to the result; a record on a stale
// CPU first zeroes that CPU's slice, a clear zeroes the current CPU's slice, and a read
// sums the counter over all CPUs. The next beat can be taken in the cycle after the result
// is loaded. The counter memory sets the pace: the controller makes at most one access per
// cycle, zeroing one entry a cycle. After reset the whole table is zeroed before a request
// is taken.
// Top level of the epoch-cleared event counter table.
module epoch_cleared_event_counter_table_unit #(
  parameter int NUM_CPUS       = 4,
  parameter int NUM_SUBSYSTEMS = 8,
  parameter int NUM_COUNTERS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  ecetbl_req_if.sink  req,
  ecetbl_rsp_if.source rsp
);

  ecetbl_pkg::cmd_t cmd;
  ecetbl_pkg::sts_t sts;

  // Sequencer
  ecetbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  ecetbl_dp #(
    .NUM_CPUS       (NUM_CPUS),
    .NUM_SUBSYSTEMS (NUM_SUBSYSTEMS),
    .NUM_COUNTERS   (NUM_COUNTERS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (req.operation),
    .in_cpu_id        (req.cpu_id),
    .in_subsystem     (req.subsystem),
    .in_counter_index (req.counter_index),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .out_status       (rsp.status),
    .out_count        (rsp.count)
  );

endmodule

>>> src/ecetbl_chk.sv
// Port-level checker for the event counter table, with its bind.
module ecetbl_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              status,
  input ecetbl_pkg::word_t count
);

  // The table sweep after reset holds off requests.
  a_init_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken right after reset");

  // One request at a time: a beat is never followed at once by another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken in the cycle after a beat");

  // An error result carries no count.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ecetbl_pkg::STATUS_ERR) |-> (count == '0))
    else $error("error result with nonzero count");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(count)))
    else $error("stalled result changed");

endmodule

bind epoch_cleared_event_counter_table_unit ecetbl_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .status    (rsp.status),
  .count     (rsp.count)
);

>>> tb/sv/ecetbl_tb_pkg.sv
// Scoreboard for the event counter table: a copy of the counter state and the results it implies.
`timescale 1ns / 100ps
package ecetbl_tb_pkg;
  import ecetbl_pkg::*;

  // Table geometry; the testbench builds the block with the same values.
  localparam int CPU_COUNT    = 4;
  localparam int SUBSYS_COUNT = 8;
  localparam int CTR_COUNT    = 16;

  // The one operation code that the block ignores.
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct {
    logic  status;
    word_t count;
  } tally_result_t;

  class counter_table_scoreboard;
    word_t         tally [CPU_COUNT][SUBSYS_COUNT][CTR_COUNT];
    word_t         cpu_epoch [CPU_COUNT];
    word_t         global_epoch;
    tally_result_t awaited_results [$];
    int            mismatches;
    int            checked;
    int            n_records;
    int            n_rejects;
    int            n_reads;
    int            n_clears;
    int            n_unused;

    // Start from the reset state: all counters zero, every CPU on epoch one.
    function new();
      foreach (tally[c, s, k]) tally[c][s][k] = '0;
      foreach (cpu_epoch[c]) cpu_epoch[c] = 32'd1;
      global_epoch = 32'd1;
      mismatches   = 0;
      checked      = 0;
      n_records    = 0;
      n_rejects    = 0;
      n_reads      = 0;
      n_clears     = 0;
      n_unused     = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void wipe_slice(int unsigned cpu);
      for (int s = 0; s < SUBSYS_COUNT; s++) begin
        for (int k = 0; k < CTR_COUNT; k++) begin
          tally[cpu][s][k] = '0;
        end
      end
    endfunction

    // Apply one accepted request beat to the copy and queue the result it must produce.
    function void note_request(op_t op, idx8_t cpu_raw, idx8_t sub, idx8_t ctr);
      int unsigned   cpu;
      logic          in_range;
      word_t         total;
      tally_result_t res;
      cpu        = (cpu_raw < CPU_COUNT) ? cpu_raw : 0;
      in_range   = (sub < SUBSYS_COUNT) && (ctr < CTR_COUNT);
      res.status = STATUS_OK;
      res.count  = '0;
      case (op)
        OP_RECORD: begin
          n_records++;
          // A bad index is rejected before the CPU is brought up to date.
          if (!in_range) begin
            n_rejects++;
            res.status = STATUS_ERR;
          end else begin
            if (cpu_epoch[cpu] != global_epoch) begin
              wipe_slice(cpu);
              cpu_epoch[cpu] = global_epoch;
            end
            tally[cpu][sub][ctr] = tally[cpu][sub][ctr] + 32'd1;
          end
        end
        OP_READ: begin
          n_reads++;
          // Only CPUs tagged with the current epoch contribute to the sum.
          if (in_range) begin
            total = '0;
            for (int c = 0; c < CPU_COUNT; c++) begin
              if (cpu_epoch[c] == global_epoch) total = total + tally[c][sub][ctr];
            end
            res.count = total;
          end
        end
        OP_CLEAR: begin
          n_clears++;
          global_epoch = global_epoch + 32'd1;
          wipe_slice(cpu);
          cpu_epoch[cpu] = global_epoch;
        end
        default: begin
          n_unused++;
        end
      endcase
      awaited_results.push_back(res);
    endfunction

    // Compare one accepted result beat with the oldest awaited result.
    task check_result(logic status, word_t count);
      tally_result_t exp;
      checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat status %0d count %0d with none awaited",
                                  status, count));
      end else begin
        exp = awaited_results.pop_front();
        if (status !== exp.status)
          report_mismatch($sformatf("status %0d, awaited %0d", status, exp.status));
        if (count !== exp.count)
          report_mismatch($sformatf("count %0d, awaited %0d", count, exp.count));
      end
    endtask

    task flush_leftovers();
      while (awaited_results.size() != 0) begin
        void'(awaited_results.pop_front());
        report_mismatch("awaited result never arrived");
      end
    endtask
  endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level testbench for the epoch-cleared event counter table unit.
`timescale 1ns / 100ps
module testbench;
  import ecetbl_pkg::*;
  import ecetbl_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int SEGMENTS     = 8;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  counter_table_scoreboard table_model;

  ecetbl_req_if req ();
  ecetbl_rsp_if rsp ();

  epoch_cleared_event_counter_table_unit #(
    .NUM_CPUS       (CPU_COUNT),
    .NUM_SUBSYSTEMS (SUBSYS_COUNT),
    .NUM_COUNTERS   (CTR_COUNT)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #2 clk = ~clk;

  // Result side: ready follows the stall rate of the current phase.
  always @(negedge clk) begin
    rsp.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Sample both channels at the rising edge; the watchdog ends a hung run.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        table_model.note_request(req.operation, req.cpu_id, req.subsystem, req.counter_index);
      if (rsp.valid && rsp.ready)
        table_model.check_result(rsp.status, rsp.count);
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Present one request beat, with optional idle cycles first, and hold it until taken.
  task send_request(input op_t op, input idx8_t cpu, input idx8_t sub, input idx8_t ctr);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid         = 1'b1;
    req.operation     = op;
    req.cpu_id        = cpu;
    req.subsystem     = sub;
    req.counter_index = ctr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the request side until every awaited result has come back.
  task drain_results();
    req.valid = 1'b0;
    while (table_model.pending() != 0) @(negedge clk);
  endtask

  // Mostly in-range requests on a few hot counters, with some noise in every field.
  task send_random_request();
    int    pick;
    op_t   op;
    idx8_t cpu;
    idx8_t sub;
    idx8_t ctr;
    pick = $urandom_range(99);
    if (pick < 55)      op = OP_RECORD;
    else if (pick < 93) op = OP_READ;
    else if (pick < 97) op = OP_CLEAR;
    else                op = OP_UNUSED;
    if ($urandom_range(99) < 85) cpu = idx8_t'($urandom_range(CPU_COUNT - 1));
    else                         cpu = idx8_t'($urandom_range(255));
    if ($urandom_range(99) < 45) begin
      sub = idx8_t'($urandom_range(1));
      ctr = idx8_t'($urandom_range(3));
    end else begin
      sub = ($urandom_range(99) < 8) ? idx8_t'($urandom_range(255))
                                     : idx8_t'($urandom_range(SUBSYS_COUNT - 1));
      ctr = ($urandom_range(99) < 8) ? idx8_t'($urandom_range(255))
                                     : idx8_t'($urandom_range(CTR_COUNT - 1));
    end
    send_request(op, cpu, sub, ctr);
  endtask

  // Set the idle and stall rates for one of the four traffic phases.
  task set_phase(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  initial begin
    table_model       = new();
    req.valid         = 1'b0;
    req.operation     = OP_RECORD;
    req.cpu_id        = '0;
    req.subsystem     = '0;
    req.counter_index = '0;
    rsp.ready         = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: index extremes, CPU mapping, bad indexes, unused code and epoch handling.
    set_phase(0);
    send_request(OP_READ,   8'd0,   8'd0,   8'd0);
    send_request(OP_RECORD, 8'd0,   8'd0,   8'd0);
    send_request(OP_RECORD, 8'd3,   8'd7,   8'd15);
    send_request(OP_RECORD, 8'd255, 8'd7,   8'd15);
    send_request(OP_RECORD, 8'd4,   8'd0,   8'd0);
    send_request(OP_RECORD, 8'd1,   8'd8,   8'd0);
    send_request(OP_RECORD, 8'd2,   8'd0,   8'd16);
    send_request(OP_RECORD, 8'd3,   8'd255, 8'd255);
    send_request(OP_READ,   8'd2,   8'd7,   8'd15);
    send_request(OP_READ,   8'd255, 8'd0,   8'd0);
    send_request(OP_READ,   8'd0,   8'd8,   8'd0);
    send_request(OP_READ,   8'd0,   8'd0,   8'd255);
    send_request(OP_UNUSED, 8'd255, 8'd255, 8'd255);
    send_request(OP_UNUSED, 8'd0,   8'd0,   8'd0);
    send_request(OP_CLEAR,  8'd1,   8'd255, 8'd255);
    send_request(OP_READ,   8'd0,   8'd0,   8'd0);
    send_request(OP_RECORD, 8'd1,   8'd0,   8'd0);
    send_request(OP_RECORD, 8'd2,   8'd0,   8'd0);
    send_request(OP_READ,   8'd3,   8'd0,   8'd0);
    // A rejected record on a stale CPU must leave that CPU stale.
    send_request(OP_RECORD, 8'd3,   8'd9,   8'd15);
    send_request(OP_READ,   8'd0,   8'd7,   8'd15);
    send_request(OP_CLEAR,  8'd200, 8'd0,   8'd0);
    send_request(OP_RECORD, 8'd3,   8'd7,   8'd15);
    send_request(OP_READ,   8'd1,   8'd7,   8'd15);
    drain_results();

    // Random part, cycling through the traffic phases in order with a full drain between them.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % (RANDOM_ITEMS / SEGMENTS) == 0) begin
        drain_results();
        set_phase((i / (RANDOM_ITEMS / SEGMENTS)) % 4);
      end
      send_random_request();
    end
    req.valid = 1'b0;

    while (table_model.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    table_model.flush_leftovers();

    $display("Run covered %0d requests: %0d records (%0d rejected), %0d reads, %0d clears,",
             table_model.n_records + table_model.n_reads + table_model.n_clears
             + table_model.n_unused, table_model.n_records, table_model.n_rejects,
             table_model.n_reads, table_model.n_clears);
    $display("%0d unused codes; %0d result beats checked, %0d mismatches.",
             table_model.n_unused, table_model.checked, table_model.mismatches);
    if (table_model.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
